// ----- design/ind_pkg.sv -----
package ind_pkg;

   // Operation codes of the request channel.
   typedef enum logic [2:0] {
      OP_INTERNAL = 3'd0,
      OP_HARDWARE = 3'd1,
      OP_EOI      = 3'd2,
      OP_PROCESS  = 3'd3,
      OP_ENABLE   = 3'd4,
      OP_DISABLE  = 3'd5
   } op_type;

   // Result kinds of the response channel.
   typedef enum logic [2:0] {
      KIND_QUEUED   = 3'd0,
      KIND_STARTED  = 3'd1,
      KIND_DONE     = 3'd2,
      KIND_REJECTED = 3'd3,
      KIND_FLUSHED  = 3'd4,
      KIND_NONE     = 3'd5
   } kind_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SECOND
   } state_type;

   // One queue or stack entry: internal flag over the vector.
   typedef struct packed {
      logic       internal;
      logic [7:0] vector;
   } entry_type;

   // One response item as it sits in the output register.
   typedef struct packed {
      kind_type          kind;
      logic [7:0]        vector;
      logic              internal;
      logic signed [31:0] value;
      logic [3:0]        nest_depth;
      logic [4:0]        pending;
      logic              waiting;
      logic              last;
   } result_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
      logic emit_second;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic has_second;
   } status_type;

   localparam logic signed [31:0] REJECT_VALUE = -32'sd1;

endpackage

// ----- design/interrupt_nesting_dispatcher_top.sv -----
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    operation, vector, cpu_irq_enable, handler_return
// rsp_      out        rsp_valid/stall    kind, out_vector, out_internal, completion_value,
//                                         nest_depth, pending_count, waiting_flag, last
//
// An item is captured, which reads the queue head and stack top from their memories,
// then executed, which loads the output register. An end of interrupt that starts
// a queued handler gives its second result from a further state.
// Reset is synchronous and empties queue and stack; the block starts disabled.
// A stalled output holds the execute step until the output register frees up.
module interrupt_nesting_dispatcher_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int NEST_DEPTH  = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic [7:0]         req_vector,
   input  logic               req_cpu_irq_enable,
   input  logic signed [31:0] req_handler_return,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic [7:0]         rsp_out_vector,
   output logic               rsp_out_internal,
   output logic signed [31:0] rsp_completion_value,
   output logic [3:0]         rsp_nest_depth,
   output logic [4:0]         rsp_pending_count,
   output logic               rsp_waiting_flag,
   output logic               rsp_last
);

   ind_pkg::cmd_type    cmd;
   ind_pkg::status_type status;
   ind_pkg::result_type item;

   ind_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ind_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .NEST_DEPTH  (NEST_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_operation      (req_operation),
      .req_vector         (req_vector),
      .req_cpu_irq_enable (req_cpu_irq_enable),
      .req_handler_return (req_handler_return),
      .rsp_item           (item)
   );

   // Response fields come straight from the output register.
   assign rsp_kind             = item.kind;
   assign rsp_out_vector       = item.vector;
   assign rsp_out_internal     = item.internal;
   assign rsp_completion_value = item.value;
   assign rsp_nest_depth       = item.nest_depth;
   assign rsp_pending_count    = item.pending;
   assign rsp_waiting_flag     = item.waiting;
   assign rsp_last             = item.last;

endmodule

// ----- design/ind_ctrl.sv -----
module ind_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ind_pkg::status_type status,
   output ind_pkg::cmd_type    cmd
);

   ind_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic               out_free;

   // The output register can take a new result when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ind_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ind_pkg::ST_IDLE: begin
            if (accept) state_in = ind_pkg::ST_EXEC;
         end
         ind_pkg::ST_EXEC: begin
            if (out_free) begin
               state_in = status.has_second ? ind_pkg::ST_SECOND : ind_pkg::ST_IDLE;
            end
         end
         ind_pkg::ST_SECOND: begin
            if (out_free) state_in = ind_pkg::ST_IDLE;
         end
         default: state_in = ind_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd = '0;
      case (state_ff)
         ind_pkg::ST_IDLE:   cmd.capture     = accept;
         ind_pkg::ST_EXEC:   cmd.commit      = out_free;
         ind_pkg::ST_SECOND: cmd.emit_second = out_free;
         default:            cmd             = '0;
      endcase
   end

   // A result stays valid until its transfer completes.
   assign rsp_valid_in = (cmd.commit || cmd.emit_second) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ind_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/ind_datapath.sv -----
module ind_datapath #(
   parameter int QUEUE_DEPTH = 16,
   parameter int NEST_DEPTH  = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  ind_pkg::cmd_type    cmd,
   output ind_pkg::status_type status,
   input  logic [2:0]          req_operation,
   input  logic [7:0]          req_vector,
   input  logic                req_cpu_irq_enable,
   input  logic signed [31:0]  req_handler_return,
   output ind_pkg::result_type rsp_item
);

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int SAW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int DW  = $clog2(NEST_DEPTH + 1);

   // Pending queue and handler stack.
   ind_pkg::entry_type fifo_mem [QUEUE_DEPTH];
   ind_pkg::entry_type stack_mem [NEST_DEPTH];

   // Latched request and registered memory reads.
   ind_pkg::op_type    op_ff;
   logic [7:0]         vec_ff;
   logic               cpu_ff;
   logic signed [31:0] ret_ff;
   ind_pkg::entry_type fifo_rd_ff;
   ind_pkg::entry_type stack_rd_ff;

   // Control state.
   logic [QAW-1:0] head_ff, head_in;
   logic [QAW-1:0] tail_ff, tail_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [DW-1:0]  depth_ff, depth_in;
   logic           enabled_ff, enabled_in;
   logic           wait_ff, wait_in;

   // Output register and the held second result.
   ind_pkg::result_type out_ff, out_in;
   ind_pkg::result_type second_ff;

   ind_pkg::result_type res1, res2;
   logic               has_second;
   logic               stack_we, fifo_we;
   logic [SAW-1:0]     stack_wa;
   ind_pkg::entry_type stack_wd;
   ind_pkg::entry_type new_entry;
   logic [SAW-1:0]     stack_ra;

   // The stack is read at its top entry.
   assign stack_ra  = (depth_ff == '0) ? '0 : SAW'(depth_ff - DW'(1));
   assign new_entry = '{internal: (op_ff == ind_pkg::OP_INTERNAL), vector: vec_ff};

   // Request capture and memory reads for the next execution step.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= ind_pkg::op_type'(req_operation);
         vec_ff      <= req_vector;
         cpu_ff      <= req_cpu_irq_enable;
         ret_ff      <= req_handler_return;
         fifo_rd_ff  <= fifo_mem[head_ff];
         stack_rd_ff <= stack_mem[stack_ra];
      end
   end

   // Memory writes happen when the operation commits.
   always_ff @(posedge clock) begin
      if (cmd.commit && fifo_we) fifo_mem[tail_ff] <= new_entry;
      if (cmd.commit && stack_we) stack_mem[stack_wa] <= stack_wd;
   end

   // Operation decode: next state and up to two results.
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      depth_in   = depth_ff;
      enabled_in = enabled_ff;
      wait_in    = wait_ff;
      stack_we   = 1'b0;
      stack_wa   = '0;
      stack_wd   = new_entry;
      fifo_we    = 1'b0;
      has_second = 1'b0;
      res1       = '0;
      res1.kind  = ind_pkg::KIND_NONE;
      res2       = '0;
      res2.kind  = ind_pkg::KIND_STARTED;

      case (op_ff)
         ind_pkg::OP_INTERNAL, ind_pkg::OP_HARDWARE: begin
            res1.vector   = new_entry.vector;
            res1.internal = new_entry.internal;
            if (!enabled_ff) begin
               res1.kind  = ind_pkg::KIND_REJECTED;
               res1.value = ind_pkg::REJECT_VALUE;
            end else if (new_entry.internal && (depth_ff < DW'(NEST_DEPTH)) &&
                         ((depth_ff == '0) || stack_rd_ff.internal)) begin
               // Internal exception nests on top of an internal handler, or starts on an empty stack.
               stack_we  = 1'b1;
               stack_wa  = SAW'(depth_ff);
               depth_in  = depth_ff + DW'(1);
               res1.kind = ind_pkg::KIND_STARTED;
            end else if (count_ff >= CW'(QUEUE_DEPTH)) begin
               res1.kind  = ind_pkg::KIND_REJECTED;
               res1.value = ind_pkg::REJECT_VALUE;
            end else begin
               fifo_we   = 1'b1;
               tail_in   = (tail_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + QAW'(1);
               count_in  = count_ff + CW'(1);
               wait_in   = 1'b1;
               res1.kind = ind_pkg::KIND_QUEUED;
            end
         end
         ind_pkg::OP_EOI: begin
            if (depth_ff != '0) begin
               depth_in      = depth_ff - DW'(1);
               res1.kind     = ind_pkg::KIND_DONE;
               res1.vector   = stack_rd_ff.vector;
               res1.internal = stack_rd_ff.internal;
               res1.value    = ret_ff;
            end
         end
         ind_pkg::OP_PROCESS: begin
            if (enabled_ff && cpu_ff && (count_ff != '0) && (depth_ff < DW'(NEST_DEPTH))) begin
               res1.kind     = ind_pkg::KIND_STARTED;
               res1.vector   = fifo_rd_ff.vector;
               res1.internal = fifo_rd_ff.internal;
               stack_we      = 1'b1;
               stack_wa      = SAW'(depth_ff);
               stack_wd      = fifo_rd_ff;
               depth_in      = depth_ff + DW'(1);
               head_in       = (head_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QAW'(1);
               count_in      = count_ff - CW'(1);
               if (count_ff == CW'(1)) wait_in = 1'b0;
            end
         end
         ind_pkg::OP_ENABLE: begin
            enabled_in = 1'b1;
         end
         ind_pkg::OP_DISABLE: begin
            if (enabled_ff) begin
               enabled_in = 1'b0;
               depth_in   = '0;
               count_in   = '0;
               head_in    = '0;
               tail_in    = '0;
               wait_in    = 1'b0;
               res1.kind  = ind_pkg::KIND_FLUSHED;
            end
         end
         default: res1.kind = ind_pkg::KIND_NONE;
      endcase

      res1.nest_depth = 4'(depth_in);
      res1.pending    = 5'(count_in);
      res1.waiting    = wait_in;

      // An EOI that empties the stack starts a queued internal head.
      if ((op_ff == ind_pkg::OP_EOI) && (depth_ff == DW'(1)) && enabled_ff && cpu_ff &&
          (count_ff != '0) && fifo_rd_ff.internal) begin
         has_second    = 1'b1;
         stack_we      = 1'b1;
         stack_wa      = '0;
         stack_wd      = fifo_rd_ff;
         depth_in      = DW'(1);
         head_in       = (head_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QAW'(1);
         count_in      = count_ff - CW'(1);
         if (count_ff == CW'(1)) wait_in = 1'b0;
         res2.vector   = fifo_rd_ff.vector;
         res2.internal = fifo_rd_ff.internal;
      end

      res1.last       = !has_second;
      res2.nest_depth = 4'(depth_in);
      res2.pending    = 5'(count_in);
      res2.waiting    = wait_in;
      res2.last       = 1'b1;
   end

   assign status.has_second = has_second;

   // Output register source.
   always_comb begin
      out_in = out_ff;
      if (cmd.commit) begin
         out_in = res1;
      end else if (cmd.emit_second) begin
         out_in = second_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (cmd.commit) second_ff <= res2;
   end

   // Control state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         depth_ff   <= '0;
         enabled_ff <= 1'b0;
         wait_ff    <= 1'b0;
      end else if (cmd.commit) begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         depth_ff   <= depth_in;
         enabled_ff <= enabled_in;
         wait_ff    <= wait_in;
      end
   end

   assign rsp_item = out_ff;

endmodule

// ----- design/ind_checker.sv -----
module ind_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [2:0]         rsp_kind,
   input logic signed [31:0] rsp_completion_value,
   input logic [3:0]         rsp_nest_depth,
   input logic [4:0]         rsp_pending_count,
   input logic               rsp_waiting_flag
);

   // A stalled result holds until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind))
      else $error("stalled result changed");

   // The block works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in work");

   // A rejected interrupt reports minus one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == 3'(ind_pkg::KIND_REJECTED)) |->
      rsp_completion_value == ind_pkg::REJECT_VALUE)
      else $error("rejected result without minus one");

   // A flush leaves nothing behind.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == 3'(ind_pkg::KIND_FLUSHED)) |->
      (rsp_nest_depth == 4'd0) && (rsp_pending_count == 5'd0) && !rsp_waiting_flag)
      else $error("flush left state behind");

   // A queued interrupt raises the waiting flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == 3'(ind_pkg::KIND_QUEUED)) |->
      rsp_waiting_flag && (rsp_pending_count != 5'd0))
      else $error("queued result without waiting flag");

endmodule

bind interrupt_nesting_dispatcher_top ind_checker u_ind_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_kind             (rsp_kind),
   .rsp_completion_value (rsp_completion_value),
   .rsp_nest_depth       (rsp_nest_depth),
   .rsp_pending_count    (rsp_pending_count),
   .rsp_waiting_flag     (rsp_waiting_flag)
);

// ----- tb/tb_interrupt_nesting_dispatcher_top.sv -----
`timescale 1ns / 1ps

module tb_interrupt_nesting_dispatcher_top;

   localparam int QUEUE_LEN = 16;
   localparam int NEST_LEN  = 8;

   // Operation codes that the block does not define; they must give no action.
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_operation = '0;
   logic [7:0]         req_vector = '0;
   logic               req_cpu_irq_enable = 1'b0;
   logic signed [31:0] req_handler_return = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_kind;
   logic [7:0]         rsp_out_vector;
   logic               rsp_out_internal;
   logic signed [31:0] rsp_completion_value;
   logic [3:0]         rsp_nest_depth;
   logic [4:0]         rsp_pending_count;
   logic               rsp_waiting_flag;
   logic               rsp_last;

   // When set, neither side inserts idle cycles.
   bit calm = 1'b0;
   int mismatch_count = 0;

   // Predicted controller state.
   ind_pkg::entry_type queue_mem [QUEUE_LEN];
   int unsigned        queue_head = 0;
   int unsigned        queue_count = 0;
   ind_pkg::entry_type nest_stack [NEST_LEN];
   int unsigned        nest_count = 0;
   bit                 ctrl_on = 1'b0;
   bit                 waiting = 1'b0;

   // Results still owed by the block, oldest first.
   ind_pkg::result_type dispatch_results_due [$];

   interrupt_nesting_dispatcher_top #(
      .QUEUE_DEPTH(QUEUE_LEN),
      .NEST_DEPTH (NEST_LEN)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_vector          (req_vector),
      .req_cpu_irq_enable  (req_cpu_irq_enable),
      .req_handler_return  (req_handler_return),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_out_vector      (rsp_out_vector),
      .rsp_out_internal    (rsp_out_internal),
      .rsp_completion_value(rsp_completion_value),
      .rsp_nest_depth      (rsp_nest_depth),
      .rsp_pending_count   (rsp_pending_count),
      .rsp_waiting_flag    (rsp_waiting_flag),
      .rsp_last            (rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Prints one mismatch line, up to a cap, and counts every one.
   task automatic report_mismatch(string msg);
      if (mismatch_count < 40) begin
         $display("ERROR %0t ns: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   // Builds one result from the current predicted state.
   function automatic ind_pkg::result_type build_result(ind_pkg::kind_type k,
                                                        ind_pkg::entry_type e,
                                                        logic signed [31:0] v);
      ind_pkg::result_type r;
      r.kind       = k;
      r.vector     = e.vector;
      r.internal   = e.internal;
      r.value      = v;
      r.nest_depth = 4'(nest_count);
      r.pending    = 5'(queue_count);
      r.waiting    = waiting;
      r.last       = 1'b0;
      return r;
   endfunction

   // Moves the queue head onto the handler stack when scheduling allows it.
   function automatic bit try_start(bit head_internal, logic cpu_ok,
                                    output ind_pkg::entry_type e);
      e = '0;
      if (!cpu_ok || queue_count == 0 || nest_count >= NEST_LEN) begin
         return 1'b0;
      end
      if (head_internal && !queue_mem[queue_head].internal) begin
         return 1'b0;
      end
      e = queue_mem[queue_head];
      queue_head = (queue_head + 1) % QUEUE_LEN;
      queue_count--;
      if (queue_count == 0) begin
         waiting = 1'b0;
      end
      nest_stack[nest_count] = e;
      nest_count++;
      return 1'b1;
   endfunction

   // Updates the predicted state for one request and queues the results it causes.
   function automatic void predict_dispatch(logic [2:0] op, logic [7:0] vec, logic cpu,
                                            logic signed [31:0] ret);
      ind_pkg::result_type r [2];
      int                  n;
      ind_pkg::entry_type  e;
      ind_pkg::entry_type  blank;
      n = 0;
      blank = '0;
      e.internal = (op == ind_pkg::OP_INTERNAL);
      e.vector = vec;
      case (op)
         ind_pkg::OP_INTERNAL, ind_pkg::OP_HARDWARE: begin
            if (!ctrl_on) begin
               r[n++] = build_result(ind_pkg::KIND_REJECTED, e, ind_pkg::REJECT_VALUE);
            end else if (op == ind_pkg::OP_INTERNAL && nest_count < NEST_LEN &&
                         (nest_count == 0 || nest_stack[nest_count - 1].internal)) begin
               nest_stack[nest_count] = e;
               nest_count++;
               r[n++] = build_result(ind_pkg::KIND_STARTED, e, 0);
            end else if (queue_count >= QUEUE_LEN) begin
               r[n++] = build_result(ind_pkg::KIND_REJECTED, e, ind_pkg::REJECT_VALUE);
            end else begin
               queue_mem[(queue_head + queue_count) % QUEUE_LEN] = e;
               queue_count++;
               waiting = 1'b1;
               r[n++] = build_result(ind_pkg::KIND_QUEUED, e, 0);
            end
         end
         ind_pkg::OP_EOI: begin
            if (nest_count == 0) begin
               r[n++] = build_result(ind_pkg::KIND_NONE, blank, 0);
            end else begin
               nest_count--;
               r[n++] = build_result(ind_pkg::KIND_DONE, nest_stack[nest_count], ret);
               // An emptied stack lets a queued internal interrupt start at once.
               if (nest_count == 0 && ctrl_on && try_start(1'b1, cpu, e)) begin
                  r[n++] = build_result(ind_pkg::KIND_STARTED, e, 0);
               end
            end
         end
         ind_pkg::OP_PROCESS: begin
            if (ctrl_on && try_start(1'b0, cpu, e)) begin
               r[n++] = build_result(ind_pkg::KIND_STARTED, e, 0);
            end else begin
               r[n++] = build_result(ind_pkg::KIND_NONE, blank, 0);
            end
         end
         ind_pkg::OP_ENABLE: begin
            ctrl_on = 1'b1;
            r[n++] = build_result(ind_pkg::KIND_NONE, blank, 0);
         end
         ind_pkg::OP_DISABLE: begin
            if (ctrl_on) begin
               ctrl_on = 1'b0;
               nest_count = 0;
               queue_count = 0;
               queue_head = 0;
               waiting = 1'b0;
               r[n++] = build_result(ind_pkg::KIND_FLUSHED, blank, 0);
            end else begin
               r[n++] = build_result(ind_pkg::KIND_NONE, blank, 0);
            end
         end
         default: begin
            r[n++] = build_result(ind_pkg::KIND_NONE, blank, 0);
         end
      endcase
      r[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) begin
         dispatch_results_due.insert(dispatch_results_due.size(), r[i]);
      end
   endfunction

   // Sends one request: optional idle gap, then hold the payload until the transfer.
   task automatic send_item(logic [2:0] op, logic [7:0] vec, logic cpu,
                            logic signed [31:0] ret);
      int gap;
      gap = 0;
      if (!calm) begin
         while ($urandom_range(99) < 34) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_vector         <= vec;
      req_cpu_irq_enable <= cpu;
      req_handler_return <= ret;
      predict_dispatch(op, vec, cpu, ret);
      do @(posedge clock); while (req_stall);
   endtask

   // Compares one accepted result with the oldest expectation.
   task automatic check_result();
      ind_pkg::result_type want;
      if (dispatch_results_due.size() == 0) begin
         report_mismatch($sformatf("result kind %0d with nothing expected", rsp_kind));
         return;
      end
      want = dispatch_results_due[0];
      dispatch_results_due.delete(0);
      if (rsp_kind !== want.kind)
         report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
      if (rsp_out_vector !== want.vector)
         report_mismatch($sformatf("vector %0d, want %0d", rsp_out_vector, want.vector));
      if (rsp_out_internal !== want.internal)
         report_mismatch($sformatf("internal %0b, want %0b", rsp_out_internal,
                                   want.internal));
      if (rsp_completion_value !== want.value)
         report_mismatch($sformatf("completion %0d, want %0d", rsp_completion_value,
                                   want.value));
      if (rsp_nest_depth !== want.nest_depth)
         report_mismatch($sformatf("nest depth %0d, want %0d", rsp_nest_depth,
                                   want.nest_depth));
      if (rsp_pending_count !== want.pending)
         report_mismatch($sformatf("pending %0d, want %0d", rsp_pending_count,
                                   want.pending));
      if (rsp_waiting_flag !== want.waiting)
         report_mismatch($sformatf("waiting %0b, want %0b", rsp_waiting_flag,
                                   want.waiting));
      if (rsp_last !== want.last)
         report_mismatch($sformatf("last %0b, want %0b", rsp_last, want.last));
   endtask

   // Result side: random stall, and a check at every result transfer.
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 34);
      if (!reset && rsp_valid && !rsp_stall) begin
         check_result();
      end
   end

   // Everything the block must refuse or ignore while disabled.
   task automatic test_disabled_controller();
      send_item(ind_pkg::OP_INTERNAL, 8'h00, 1'b1, 0);
      send_item(ind_pkg::OP_HARDWARE, 8'hFF, 1'b1, 0);
      send_item(ind_pkg::OP_EOI, 8'h00, 1'b1, 0);
      send_item(ind_pkg::OP_PROCESS, 8'h00, 1'b1, 0);
      send_item(ind_pkg::OP_DISABLE, 8'h00, 1'b0, 0);
      send_item(OP_SPARE_A, 8'h00, 1'b1, 0);
      send_item(OP_SPARE_B, 8'hFF, 1'b0, -32'sd1);
   endtask

   // Nesting, queueing, scheduling and the two-result end of interrupt.
   task automatic test_nesting_and_queue();
      send_item(ind_pkg::OP_ENABLE, 8'h00, 1'b0, 0);
      send_item(ind_pkg::OP_ENABLE, 8'h00, 1'b0, 0);
      send_item(ind_pkg::OP_HARDWARE, 8'h5A, 1'b1, 0);
      send_item(ind_pkg::OP_INTERNAL, 8'hA5, 1'b1, 0);
      send_item(ind_pkg::OP_INTERNAL, 8'hFF, 1'b1, 0);
      send_item(ind_pkg::OP_PROCESS, 8'h00, 1'b0, 0);
      send_item(ind_pkg::OP_PROCESS, 8'h00, 1'b1, 0);
      send_item(ind_pkg::OP_INTERNAL, 8'h01, 1'b1, 0);
      send_item(ind_pkg::OP_EOI, 8'h00, 1'b1, 32'sh7FFF_FFFF);
      send_item(ind_pkg::OP_EOI, 8'h00, 1'b1, 32'sh8000_0000);
      send_item(ind_pkg::OP_EOI, 8'h00, 1'b1, -32'sd1);
      send_item(ind_pkg::OP_HARDWARE, 8'h80, 1'b1, 0);
      send_item(ind_pkg::OP_EOI, 8'h00, 1'b1, 0);
      send_item(ind_pkg::OP_INTERNAL, 8'h7F, 1'b1, 0);
      send_item(ind_pkg::OP_EOI, 8'h00, 1'b0, 32'sh1234_5678);
   endtask

   // Disable flushes once, and a second disable does nothing.
   task automatic test_flush();
      send_item(ind_pkg::OP_DISABLE, 8'h00, 1'b1, 0);
      send_item(ind_pkg::OP_DISABLE, 8'h00, 1'b1, 0);
   endtask

   // Random episodes: usually an enable, a run of mostly arrivals or a balanced mix, then often
   // a flush. Arrival-heavy runs fill the stack and the queue.
   task automatic test_random_episodes();
      int         sent;
      int         span;
      int         arrival_pct;
      int         pick;
      logic [2:0] op;
      logic [7:0] vec;
      logic       cpu;
      sent = 0;
      while (sent < 1000) begin
         calm = (sent >= 400 && sent < 600);
         span = $urandom_range(60, 8);
         arrival_pct = ($urandom_range(1) != 0) ? 75 : 45;
         if ($urandom_range(9) != 0) begin
            send_item(ind_pkg::OP_ENABLE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      $urandom);
            sent++;
         end
         repeat (span) begin
            pick = $urandom_range(99);
            if ($urandom_range(7) == 0)
               vec = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            else
               vec = 8'($urandom_range(255));
            cpu = ($urandom_range(3) != 0);
            if (pick < arrival_pct)
               op = ($urandom_range(2) != 0) ? ind_pkg::OP_INTERNAL : ind_pkg::OP_HARDWARE;
            else if (pick < 91)
               op = ($urandom_range(1) != 0) ? ind_pkg::OP_EOI : ind_pkg::OP_PROCESS;
            else if (pick < 94)
               op = ind_pkg::OP_ENABLE;
            else if (pick < 97)
               op = ind_pkg::OP_DISABLE;
            else
               op = ($urandom_range(1) != 0) ? OP_SPARE_A : OP_SPARE_B;
            send_item(op, vec, cpu, $urandom);
            sent++;
         end
         if ($urandom_range(2) == 0) begin
            send_item(ind_pkg::OP_DISABLE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      $urandom);
            sent++;
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      int drain_cycles;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_disabled_controller();
      test_nesting_and_queue();
      test_flush();
      test_random_episodes();
      req_valid <= 1'b0;
      // Let the remaining results drain, then watch a few more cycles for strays.
      drain_cycles = 0;
      while (dispatch_results_due.size() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (dispatch_results_due.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", dispatch_results_due.size()));
      end
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #3_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/ind_pkg.sv
design/ind_ctrl.sv
design/ind_datapath.sv
design/interrupt_nesting_dispatcher_top.sv
design/ind_checker.sv
tb/tb_interrupt_nesting_dispatcher_top.sv
